[rtl/sscfp_pkg.sv]
// Shared types and constants of the sync/length/checksum frame parser.
// Used by every module of the block and by its port checker; depends on nothing.
package sscfp_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSTHROUGH = 1'b1;

  localparam logic [7:0] SYNC_BYTE_RESET = 8'h5A;

  // Input command codes.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_RAW  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Queue between front and back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_length;
    logic [7:0]  out_byte;
    logic [15:0] byte_index;
    logic        checksum_ok;
    logic        last;
  } out_item_t;

  // Classification made by the front part.
  typedef enum logic [1:0] {
    OP_FLUSH,
    OP_RAW,
    OP_FRAME
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       is_sync;
    logic [7:0] rx_byte;
  } q_entry_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_CHECK
  } phase_t;

endpackage

[rtl/sscfp_front.sv]
// Front part: configuration registers, input acceptance and classification.
// Depends on sscfp_pkg.
module sscfp_front import sscfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output q_entry_t              q_push_data
);

  logic [7:0] sync_byte;
  logic       passthrough_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte        <= SYNC_BYTE_RESET;
      passthrough_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE:   sync_byte        <= cfg_data;
        CFG_PASSTHROUGH: passthrough_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_data.rx_byte = in_data.rx_byte;
    q_push_data.is_sync = (in_data.rx_byte == sync_byte);
    if (in_data.cmd == CMD_FLUSH) begin
      q_push_data.op = OP_FLUSH;
    end else if (passthrough_mode) begin
      q_push_data.op = OP_RAW;
    end else begin
      q_push_data.op = OP_FRAME;
    end
  end

endmodule

[rtl/sscfp_queue.sv]
// Short first-in first-out queue of classified transactions between front and back.
// Depends on sscfp_pkg.
module sscfp_queue import sscfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head_data
);

  q_entry_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/sscfp_back.sv]
// Back part: frame state machine, checksum accumulation and output register.
// Depends on sscfp_pkg.
module sscfp_back import sscfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  q_entry_t  head_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  phase_t      phase, phase_next;
  logic [7:0]  held_cmd, held_cmd_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] data_count, data_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        emit;
  out_item_t   result;
  logic [15:0] count_inc;
  logic [15:0] length_full;

  // A queued transaction is taken only when the output register can hold its result.
  assign pop = head_valid && (!out_valid || !out_stall);

  assign count_inc   = data_count + 16'd1;
  assign length_full = {head_data.rx_byte, held_length[7:0]};

  always_comb begin
    phase_next       = phase;
    held_cmd_next    = held_cmd;
    held_length_next = held_length;
    data_count_next  = data_count;
    running_sum_next = running_sum;
    emit             = 1'b0;
    result           = '0;
    result.out_byte  = head_data.rx_byte;
    case (head_data.op)
      OP_FLUSH: begin
        phase_next = PH_HUNT;
      end
      OP_RAW: begin
        phase_next  = PH_HUNT;
        emit        = 1'b1;
        result.kind = KIND_RAW;
      end
      OP_FRAME: begin
        case (phase)
          PH_HUNT: begin
            if (head_data.is_sync) begin
              running_sum_next = '0;
              data_count_next  = '0;
              phase_next       = PH_CMD;
            end
          end
          PH_CMD: begin
            held_cmd_next    = head_data.rx_byte;
            running_sum_next = head_data.rx_byte;
            phase_next       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            held_length_next = {8'd0, head_data.rx_byte};
            running_sum_next = running_sum + head_data.rx_byte;
            phase_next       = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            held_length_next = length_full;
            running_sum_next = running_sum + head_data.rx_byte;
            data_count_next  = '0;
            phase_next       = (length_full == 16'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            emit                = 1'b1;
            result.kind         = KIND_DATA;
            result.frame_cmd    = held_cmd;
            result.frame_length = held_length;
            result.byte_index   = data_count;
            running_sum_next    = running_sum + head_data.rx_byte;
            data_count_next     = count_inc;
            if (count_inc == held_length) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            emit                = 1'b1;
            result.kind         = KIND_END;
            result.frame_cmd    = held_cmd;
            result.frame_length = held_length;
            result.checksum_ok  = (~running_sum == head_data.rx_byte);
            result.last         = 1'b1;
            phase_next          = PH_HUNT;
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      held_cmd    <= '0;
      held_length <= '0;
      data_count  <= '0;
      running_sum <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      held_cmd    <= held_cmd_next;
      held_length <= held_length_next;
      data_count  <= data_count_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= result;
    end
  end

endmodule

[rtl/sum_checksum_frame_parser.sv]
// Top level of the sync/length/checksum frame parser: front, queue and back.
// Depends on sscfp_pkg, sscfp_front, sscfp_queue and sscfp_back.
//
//   Channel   Direction  Handshake           Payload
//   in        input      in_valid/in_stall   in_data   (cmd, rx_byte)
//   out       output     out_valid/out_stall out_data  (kind ... last)
//   cfg       input      cfg_we              cfg_index, cfg_data
//
// One input transaction is accepted every cycle while the four-entry queue has
// room. An accepted transaction is written into the queue; its result, if any,
// is registered in the output register when the back part pops it.
// The back part takes one queued transaction per cycle, limited by the single
// output register: it pops only when that register is empty or being taken.
// Reset is synchronous and active high; it clears the queue, the frame state,
// the output valid and the configuration registers (sync byte 0x5A, framing).
// A stall on the output fills the queue; in_stall rises only when it is full.
module sum_checksum_frame_parser import sscfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic     q_full;
  logic     q_push;
  q_entry_t q_push_data;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head_data;

  // The front classifies each transaction as flush, raw echo or frame byte and
  // compares the byte against the sync byte while it still has the registers.
  sscfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  sscfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  // The back walks the frame phases, keeps the running sum and the data index,
  // and drives the output register.
  sscfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[rtl/sscfp_checker.sv]
// Port checker for the frame parser, bound to the top level.
// Depends on sscfp_pkg and sum_checksum_frame_parser.
module sscfp_checker import sscfp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.kind == KIND_RAW || out_data.kind == KIND_DATA ||
                  out_data.kind == KIND_END)
    else $error("illegal result kind");

  a_last_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == (out_data.kind == KIND_END)) &&
                  (out_data.kind == KIND_END || !out_data.checksum_ok))
    else $error("last or checksum flag outside frame end");

  a_raw_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_RAW |->
      out_data.frame_cmd == 8'd0 && out_data.frame_length == 16'd0 &&
      out_data.byte_index == 16'd0)
    else $error("raw transaction carries frame fields");

endmodule

bind sum_checksum_frame_parser sscfp_checker u_sscfp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
